// File: sv/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types and constants for the HTTP request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    // Characters
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Line regions
    localparam logic [1:0] REGION_METHOD  = 2'd0;
    localparam logic [1:0] REGION_TARGET  = 2'd1;
    localparam logic [1:0] REGION_VERSION = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_PATH   = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_REQUEST  = 3'd1;
    localparam logic [2:0] ST_URI_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_BAD_METHOD   = 3'd3;
    localparam logic [2:0] ST_NOT_IMPL     = 3'd4;
    localparam logic [2:0] ST_BAD_VERSION  = 3'd5;

    localparam logic [1:0]  METHOD_LEN      = 2'd3;
    localparam logic [3:0]  VERSION_LEN     = 4'd8;
    localparam logic [15:0] LINE_COUNT_MAX  = 16'hFFFF;
    localparam logic [15:0] MAX_LINE_RESET  = 16'd8190;

    // Result queue geometry
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    typedef struct packed {
        logic [1:0]  line_region;
        logic        in_query;
        logic        cr_held;
        logic [15:0] line_count;
        logic [1:0]  method_pos;
        logic        method_bad;
        logic [3:0]  version_pos;
        logic        version_bad;
        logic        target_seen;
        logic        target_bad_start;
        logic        quote_seen;
        logic        line_done;
    } parse_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       run_end;
    } result_t;

endpackage

// File: sv/http_request_line_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// Splits an HTTP request line into path and query bytes plus one status.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+--------------
//  in      | in_byte, end_of_request                   | in  | in_valid/in_stall
//  out     | kind, out_byte, status, run_end           | out | out_valid/out_stall
//  cfg     | cfg_data (max_line_length)                | in  | cfg_valid/cfg_ready
//
//  One input beat per cycle while in_stall is low. Each beat lands in the input
//  stage register and is parsed from there by the step logic when the queue has
//  room; the step logic writes up to two results into a four-entry result queue.
//  Sustained rate: one input beat per cycle while each beat gives at most one
//  result and out_stall stays low; the output port moves one result per beat, so
//  a beat with a held CR plus a target byte needs two output beats.
//  Reset clears the parse state, the queue and sets max_line_length to 8190.
//  in_stall rises while the stage holds a beat and the queue has fewer than
//  two free entries.
//
module http_request_line_parser_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_request,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [2:0]  status,
    output logic        run_end,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    // Configuration
    logic [15:0] max_len_reg;

    // Input stage
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic [7:0]  stage_byte_reg;
    logic        stage_eor_reg;
    logic        in_accept;
    logic        process;

    // Parse state
    hrlp_pkg::parse_state_t state_reg;
    hrlp_pkg::parse_state_t state_next;

    // Step results
    logic [1:0]          res_cnt;
    hrlp_pkg::result_t   res0;
    hrlp_pkg::result_t   res1;
    logic [1:0]          push_cnt;

    // Queue
    hrlp_pkg::result_t                 q_head;
    logic                              q_not_empty;
    logic                              q_room;
    logic [hrlp_pkg::RQ_CNT_W-1:0]     q_count;
    logic                              q_pop;

    // Config port always takes a write; software writes only while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= hrlp_pkg::MAX_LINE_RESET;
        else if (cfg_valid && cfg_ready)
            max_len_reg <= cfg_data;
    end

    // Hold the staged beat until the queue has room for its worst case
    assign process   = stage_valid_reg && q_room;
    assign in_stall  = stage_valid_reg && !q_room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_accept)
            stage_valid_next = 1'b1;
        else if (process)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    // Payload of the stage needs no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg <= in_byte;
            stage_eor_reg  <= end_of_request;
        end
    end

    hrlp_step u_step
    (
        .state           (state_reg),
        .in_byte         (stage_byte_reg),
        .end_of_request  (stage_eor_reg),
        .max_line_length (max_len_reg),
        .state_next      (state_next),
        .res_cnt         (res_cnt),
        .res0            (res0),
        .res1            (res1)
    );

    // Advance the parse state only on a processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (process)
            state_reg <= state_next;
    end

    assign push_cnt = process ? res_cnt : 2'd0;
    assign q_pop    = q_not_empty && !out_stall;

    hrlp_result_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .room      (q_room),
        .count     (q_count)
    );

    assign out_valid = q_not_empty;
    assign kind      = q_head.kind;
    assign out_byte  = q_head.out_byte;
    assign status    = q_head.status;
    assign run_end   = q_head.run_end;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= hrlp_pkg::RQ_CNT_W'(hrlp_pkg::RQ_DEPTH))
        else $error("result queue overflow");

    // A status result always closes the run of its beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && res_cnt != 2'd0 && res1.kind == hrlp_pkg::KIND_STATUS)
        |-> (res_cnt == 2'd1 && res0.run_end))
        else $error("status result not last of its beat");

    // A beat ending the request leaves the parser in its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && stage_eor_reg) |=> (state_reg == '0))
        else $error("parse state not cleared at end of request");

    // Nothing is produced after the line is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && state_reg.line_done) |-> (res_cnt == 2'd0))
        else $error("result after end of request line");

endmodule

// File: sv/hrlp_step.sv
// ----------------------------------------------------------------------------
// hrlp_step
// Per-byte parse step: next state and up to two results for one beat.
// ----------------------------------------------------------------------------
module hrlp_step
(
    input  hrlp_pkg::parse_state_t state,
    input  logic [7:0]             in_byte,
    input  logic                   end_of_request,
    input  logic [15:0]            max_line_length,
    output hrlp_pkg::parse_state_t state_next,
    output logic [1:0]             res_cnt,
    output hrlp_pkg::result_t      res0,
    output hrlp_pkg::result_t      res1
);

    typedef struct packed {
        hrlp_pkg::parse_state_t st;
        logic                   emit;
        logic [1:0]             kind;
    } line_step_t;

    function automatic logic [7:0] method_char(input logic [1:0] pos);
        logic [7:0] c;
        case (pos)
            2'd0:    c = 8'h47; // G
            2'd1:    c = 8'h45; // E
            2'd2:    c = 8'h54; // T
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] version_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h48; // H
            4'd1:    c = 8'h54; // T
            4'd2:    c = 8'h54; // T
            4'd3:    c = 8'h50; // P
            4'd4:    c = 8'h2F; // /
            4'd5:    c = 8'h31; // 1
            4'd6:    c = 8'h2E; // .
            4'd7:    c = 8'h31; // 1
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic line_step_t line_byte(input hrlp_pkg::parse_state_t s_in,
                                             input logic [7:0] b);
        line_step_t r;
        r.st   = s_in;
        r.emit = 1'b0;
        r.kind = hrlp_pkg::KIND_PATH;
        if (s_in.line_count != hrlp_pkg::LINE_COUNT_MAX)
            r.st.line_count = s_in.line_count + 16'd1;
        case (s_in.line_region)
            hrlp_pkg::REGION_METHOD:
            begin
                if (b == hrlp_pkg::CH_SP)
                    r.st.line_region = hrlp_pkg::REGION_TARGET;
                else if (s_in.method_pos < hrlp_pkg::METHOD_LEN &&
                         b == method_char(s_in.method_pos))
                    r.st.method_pos = s_in.method_pos + 2'd1;
                else
                    r.st.method_bad = 1'b1;
            end
            hrlp_pkg::REGION_TARGET:
            begin
                if (b == hrlp_pkg::CH_SP)
                begin
                    r.st.line_region = hrlp_pkg::REGION_VERSION;
                end
                else
                begin
                    if (!s_in.target_seen)
                    begin
                        r.st.target_seen      = 1'b1;
                        r.st.target_bad_start = (b != hrlp_pkg::CH_SLASH);
                    end
                    if (b == hrlp_pkg::CH_QUOTE)
                        r.st.quote_seen = 1'b1;
                    if (s_in.in_query)
                    begin
                        r.emit = 1'b1;
                        r.kind = hrlp_pkg::KIND_QUERY;
                    end
                    else if (b == hrlp_pkg::CH_QUEST)
                    begin
                        r.st.in_query = 1'b1;
                    end
                    else
                    begin
                        r.emit = 1'b1;
                    end
                end
            end
            default:
            begin
                if (s_in.version_pos < hrlp_pkg::VERSION_LEN &&
                    b == version_char(s_in.version_pos))
                    r.st.version_pos = s_in.version_pos + 4'd1;
                else
                    r.st.version_bad = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [2:0] final_status(input hrlp_pkg::parse_state_t s_in,
                                                input logic [15:0] max_len);
        logic [2:0] st;
        if ({1'b0, s_in.line_count} + 17'd2 > {1'b0, max_len})
            st = hrlp_pkg::ST_URI_TOO_LONG;
        else if (s_in.line_region != hrlp_pkg::REGION_VERSION)
            st = hrlp_pkg::ST_BAD_REQUEST;
        else if (s_in.method_bad || s_in.method_pos != hrlp_pkg::METHOD_LEN)
            st = hrlp_pkg::ST_BAD_METHOD;
        else if (!s_in.target_seen || s_in.target_bad_start)
            st = hrlp_pkg::ST_NOT_IMPL;
        else if (s_in.quote_seen)
            st = hrlp_pkg::ST_BAD_REQUEST;
        else if (s_in.version_bad || s_in.version_pos != hrlp_pkg::VERSION_LEN)
            st = hrlp_pkg::ST_BAD_VERSION;
        else
            st = hrlp_pkg::ST_OK;
        return st;
    endfunction

    hrlp_pkg::parse_state_t s_mid;
    line_step_t             lb_cr;
    line_step_t             lb_cur;
    hrlp_pkg::result_t      r_cr;
    hrlp_pkg::result_t      r_cur;
    logic                   e_cr;
    logic                   e_cur;

    // Held CR first, as an ordinary line byte, then the current byte
    always_comb
    begin
        s_mid         = state;
        s_mid.cr_held = 1'b0;
        lb_cr         = line_byte(s_mid, hrlp_pkg::CH_CR);
        if (state.cr_held)
            lb_cur = line_byte(lb_cr.st, in_byte);
        else
            lb_cur = line_byte(s_mid, in_byte);
    end

    always_comb
    begin
        state_next = state;
        e_cr       = 1'b0;
        e_cur      = 1'b0;
        r_cr       = '0;
        r_cur      = '0;
        if (!state.line_done)
        begin
            if (state.cr_held && in_byte == hrlp_pkg::CH_LF)
            begin
                state_next.cr_held   = 1'b0;
                state_next.line_done = 1'b1;
                e_cur                = 1'b1;
                r_cur.kind           = hrlp_pkg::KIND_STATUS;
                r_cur.status         = final_status(state, max_line_length);
            end
            else if (end_of_request)
            begin
                e_cur        = 1'b1;
                r_cur.kind   = hrlp_pkg::KIND_STATUS;
                r_cur.status = hrlp_pkg::ST_BAD_REQUEST;
            end
            else
            begin
                if (state.cr_held)
                begin
                    e_cr           = lb_cr.emit;
                    r_cr.kind      = lb_cr.kind;
                    r_cr.out_byte  = hrlp_pkg::CH_CR;
                    state_next     = lb_cr.st;
                end
                if (in_byte == hrlp_pkg::CH_CR)
                begin
                    state_next.cr_held = 1'b1;
                end
                else
                begin
                    state_next     = lb_cur.st;
                    e_cur          = lb_cur.emit;
                    r_cur.kind     = lb_cur.kind;
                    r_cur.out_byte = in_byte;
                end
            end
        end
        if (end_of_request)
            state_next = '0;
        r_cur.run_end = e_cur;
        r_cr.run_end  = !e_cur;
    end

    assign res0    = e_cr ? r_cr : r_cur;
    assign res1    = r_cur;
    assign res_cnt = {1'b0, e_cr} + {1'b0, e_cur};

endmodule

// File: sv/hrlp_result_queue.sv
// ----------------------------------------------------------------------------
// hrlp_result_queue
// Small result queue: takes up to two results a cycle, gives one a beat.
// ----------------------------------------------------------------------------
module hrlp_result_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  hrlp_pkg::result_t   push0,
    input  hrlp_pkg::result_t   push1,
    input  logic                pop,
    output hrlp_pkg::result_t   head,
    output logic                not_empty,
    output logic                room,
    output logic [hrlp_pkg::RQ_CNT_W-1:0] count
);

    hrlp_pkg::result_t                mem [hrlp_pkg::RQ_DEPTH];
    logic [hrlp_pkg::RQ_PTR_W-1:0]    wr_ptr_reg;
    logic [hrlp_pkg::RQ_PTR_W-1:0]    wr_ptr_next;
    logic [hrlp_pkg::RQ_PTR_W-1:0]    rd_ptr_reg;
    logic [hrlp_pkg::RQ_PTR_W-1:0]    rd_ptr_next;
    logic [hrlp_pkg::RQ_CNT_W-1:0]    count_reg;
    logic [hrlp_pkg::RQ_CNT_W-1:0]    count_next;
    logic [hrlp_pkg::RQ_PTR_W-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + {{(hrlp_pkg::RQ_PTR_W-1){1'b0}}, 1'b1};
    assign wr_ptr_next  = wr_ptr_reg + push_cnt[hrlp_pkg::RQ_PTR_W-1:0];
    assign rd_ptr_next  = rd_ptr_reg + {{(hrlp_pkg::RQ_PTR_W-1){1'b0}}, pop};
    assign count_next   = count_reg
                        + {{(hrlp_pkg::RQ_CNT_W-2){1'b0}}, push_cnt}
                        - {{(hrlp_pkg::RQ_CNT_W-1){1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_ptr_reg] <= push0;
        if (push_cnt == 2'd2)
            mem[wr_ptr_plus1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= hrlp_pkg::RQ_CNT_W'(hrlp_pkg::RQ_DEPTH - 2));
    assign count     = count_reg;

endmodule
